@@ src/l4cs_pkg.sv @@
// shared types, constants and ones' complement helper for the checksum recompute block
package l4cs_pkg;

	// fixed word positions inside the ip header
	localparam logic [15:0] POS_VER_IHL    = 16'd0;
	localparam logic [15:0] POS_PROTO      = 16'd4;
	localparam logic [15:0] POS_CHECK      = 16'd5;
	localparam logic [15:0] POS_SADDR_LO   = 16'd6;
	localparam logic [15:0] POS_DADDR_HI   = 16'd9;
	localparam logic [15:0] POS_MAX        = 16'hffff;

	// checksum word offsets inside the transport segment
	localparam logic [15:0] OFF_TCP_CSUM   = 16'd8;
	localparam logic [15:0] OFF_UDP_CSUM   = 16'd3;

	// protocol numbers
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;

	// smallest legal header, in 16-bit words
	localparam logic [4:0]  MIN_HDR_WORDS  = 5'd10;

	// last_word_bytes code for a single valid byte
	localparam logic [1:0]  LAST_BYTES_ONE = 2'd1;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_TCP  = 2'd1,
		KIND_UDP  = 2'd2
	} kind_t;

	// sums and flags of one finished packet
	typedef struct packed {
		logic [15:0] hdr_sum;
		logic [15:0] seg_sum;
		logic [7:0]  proto;
		logic [15:0] seg_bytes;
		kind_t       kind;
		logic        err;
	} fin_t;

	// 16-bit end-around-carry addition
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

@@ src/l4cs_accum.sv @@
// per-word accumulator: header and segment sums, position and protocol tracking
module l4cs_accum (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [15:0]       word,
	input  logic              last,
	input  logic              odd,
	output l4cs_pkg::fin_t    fin
);

	logic [15:0] pos_q;
	logic [4:0]  hdr_words_q;
	logic [7:0]  proto_q;
	logic [15:0] hdr_sum_q;
	logic [15:0] seg_sum_q;
	logic [15:0] seg_bytes_q;

	logic [15:0] w;
	logic [4:0]  hw_eff;
	logic [7:0]  proto_eff;
	l4cs_pkg::kind_t kind;
	logic        in_hdr;
	logic [15:0] off;
	logic        skip;
	logic [15:0] hdr_sum_nx;
	logic [15:0] seg_sum_nx;
	logic [15:0] seg_bytes_nx;
	logic [17:0] total;
	logic [17:0] twice_hw;

	// pad an odd last byte and pick up header length and protocol as they pass
	always_comb begin
		w         = odd ? {word[15:8], 8'h00} : word;
		hw_eff    = (pos_q == l4cs_pkg::POS_VER_IHL) ? {w[11:8], 1'b0} : hdr_words_q;
		proto_eff = (pos_q == l4cs_pkg::POS_PROTO) ? w[7:0] : proto_q;
		case (proto_eff)
			l4cs_pkg::PROTO_TCP: kind = l4cs_pkg::KIND_TCP;
			l4cs_pkg::PROTO_UDP: kind = l4cs_pkg::KIND_UDP;
			default:             kind = l4cs_pkg::KIND_NONE;
		endcase
	end

	// running sums
	always_comb begin
		in_hdr = pos_q < {11'd0, hw_eff};
		off    = pos_q - {11'd0, hw_eff};
		skip   = (kind == l4cs_pkg::KIND_TCP && off == l4cs_pkg::OFF_TCP_CSUM) ||
			(kind == l4cs_pkg::KIND_UDP && off == l4cs_pkg::OFF_UDP_CSUM);
		hdr_sum_nx   = hdr_sum_q;
		seg_sum_nx   = seg_sum_q;
		seg_bytes_nx = seg_bytes_q;
		if (in_hdr) begin
			if (pos_q != l4cs_pkg::POS_CHECK) begin
				hdr_sum_nx = l4cs_pkg::oc_add(hdr_sum_q, w);
			end
			if (pos_q >= l4cs_pkg::POS_SADDR_LO && pos_q <= l4cs_pkg::POS_DADDR_HI) begin
				seg_sum_nx = l4cs_pkg::oc_add(seg_sum_q, w);
			end
		end else begin
			if (!skip) begin
				seg_sum_nx = l4cs_pkg::oc_add(seg_sum_q, w);
			end
			seg_bytes_nx = seg_bytes_q + {14'd0, ~odd, odd};
		end
	end

	// length checks on the final word
	always_comb begin
		total    = {1'b0, pos_q, 1'b0} + {16'd0, ~odd, odd};
		twice_hw = {12'd0, hw_eff, 1'b0};
		fin.hdr_sum   = hdr_sum_nx;
		fin.seg_sum   = seg_sum_nx;
		fin.proto     = proto_eff;
		fin.seg_bytes = seg_bytes_nx;
		fin.kind      = kind;
		fin.err       = (hw_eff < l4cs_pkg::MIN_HDR_WORDS) || (total < twice_hw);
	end

	// packet state, cleared after each final word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			hdr_words_q <= '0;
			proto_q     <= '0;
			hdr_sum_q   <= '0;
			seg_sum_q   <= '0;
			seg_bytes_q <= '0;
		end else if (take) begin
			if (last) begin
				pos_q       <= '0;
				hdr_words_q <= '0;
				proto_q     <= '0;
				hdr_sum_q   <= '0;
				seg_sum_q   <= '0;
				seg_bytes_q <= '0;
			end else begin
				if (pos_q != l4cs_pkg::POS_MAX) begin
					pos_q <= pos_q + 16'd1;
				end
				hdr_words_q <= hw_eff;
				proto_q     <= proto_eff;
				hdr_sum_q   <= hdr_sum_nx;
				seg_sum_q   <= seg_sum_nx;
				seg_bytes_q <= seg_bytes_nx;
			end
		end
	end

`ifndef SYNTHESIS
	// a final word leaves a clean state for the next packet
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		take && last |=> pos_q == '0 && hdr_sum_q == '0 && seg_sum_q == '0 &&
		seg_bytes_q == '0)
		else $error("packet state not cleared after final word");

	// position steps by one per non-final word until it saturates
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		take && !last && pos_q != l4cs_pkg::POS_MAX |=> pos_q == $past(pos_q) + 16'd1)
		else $error("word position did not advance");

	// state holds while no word is taken
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(pos_q) && $stable(hdr_sum_q) && $stable(seg_sum_q) &&
		$stable(seg_bytes_q))
		else $error("packet state changed without a word");
`endif

endmodule

@@ src/ipv4_l4_checksum_recompute.sv @@
// top level: ipv4 header and tcp/udp checksum recompute over a word stream
//
// Input stream: one 16-bit packet word per transaction, first byte in the
// high half; tlast marks the final word of a packet and tuser gives the
// valid bytes in that word (1 means the low byte is padding).
// Output stream: one transaction per packet, after its final word, with the
// recomputed header checksum, the transport checksum, the transport kind
// and an error flag (header length under 10 16-bit words or packet cut short).
// The result passes through the input register, the packet result register
// and the output register.
// Throughput: one word per cycle while the output is not stalled; the single
// end-around-carry add per sum sets the per-word path, so back-to-back packets run at full rate.
// Reset clears all packet state and empties the pipeline.
// While the receiver stalls, non-final words keep flowing into the sums;
// a final word waits in the input register only once both the result
// register and the output register are full.
module ipv4_l4_checksum_recompute (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] packet_word
	input  logic        s_axis_tlast,
	input  logic [1:0]  s_axis_tuser,   // [1:0] last_word_bytes
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [15:0] ip_header_checksum, [31:16] transport_checksum
	output logic [2:0]  m_axis_tuser    // [1:0] transport_kind, [2] packet_error
);

	logic            in_valid_s1;
	logic [15:0]     word_s1;
	logic            last_s1;
	logic            odd_s1;
	logic            take;
	l4cs_pkg::fin_t  fin_nx;
	logic            fin_valid_s2;
	l4cs_pkg::fin_t  fin_s2;
	logic            s2_ready;
	logic            out_ready;
	logic            out_valid_q;
	logic [31:0]     out_data_q;
	logic [2:0]      out_user_q;
	logic [17:0]     t_sum;
	logic [16:0]     t_fold;
	logic [15:0]     t_res;
	logic [15:0]     ip_csum;
	logic [15:0]     tr_csum;
	l4cs_pkg::kind_t kind_out;

	// stage handshakes
	assign out_ready     = !out_valid_q || m_axis_tready;
	assign s2_ready      = !fin_valid_s2 || out_ready;
	assign take          = in_valid_s1 && (!last_s1 || s2_ready);
	assign s_axis_tready = !in_valid_s1 || take;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			word_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
			odd_s1  <= s_axis_tlast && (s_axis_tuser == l4cs_pkg::LAST_BYTES_ONE);
		end
	end

	l4cs_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.word   (word_s1),
		.last   (last_s1),
		.odd    (odd_s1),
		.fin    (fin_nx)
	);

	// packet result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			fin_valid_s2 <= take && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && last_s1) begin
			fin_s2 <= fin_nx;
		end
	end

	// pseudo-header protocol and length folded into the segment sum
	always_comb begin
		t_sum  = {2'd0, fin_s2.seg_sum} + {10'd0, fin_s2.proto} + {2'd0, fin_s2.seg_bytes};
		t_fold = {1'b0, t_sum[15:0]} + {15'd0, t_sum[17:16]};
		t_res  = t_fold[15:0] + {15'd0, t_fold[16]};
		ip_csum  = '0;
		tr_csum  = '0;
		kind_out = l4cs_pkg::KIND_NONE;
		if (!fin_s2.err) begin
			ip_csum = ~fin_s2.hdr_sum;
			if (fin_s2.kind != l4cs_pkg::KIND_NONE) begin
				tr_csum  = ~t_res;
				kind_out = fin_s2.kind;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= fin_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && fin_valid_s2) begin
			out_data_q <= {tr_csum, ip_csum};
			out_user_q <= {fin_s2.err, kind_out};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

`ifndef SYNTHESIS
	// an errored packet carries no checksums and no kind
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tdata == '0 &&
		m_axis_tuser[1:0] == l4cs_pkg::KIND_NONE)
		else $error("error result carries nonzero fields");

	// no transport kind means no transport checksum
	a_kind_none: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1:0] == l4cs_pkg::KIND_NONE |->
		m_axis_tdata[31:16] == '0)
		else $error("transport checksum without transport kind");

	// a packet result waiting on a full output register is held
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fin_valid_s2 && !out_ready |=> fin_valid_s2 && $stable(fin_s2))
		else $error("packet result lost while stalled");
`endif

endmodule
